### src/qida_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qida_pkg;

  localparam int QUEUE_COUNT = 16;
  localparam int OWNER_BITS  = 16;
  localparam int QIDX_W      = $clog2(QUEUE_COUNT);
  localparam int GRANT_W     = 4;
  localparam int FREED_W     = 16;
  localparam int INDEX_W     = 8;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CHECK   = 2'd3
  } qida_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_INVALID  = 2'd2,
    ST_MISMATCH = 2'd3
  } qida_status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_WAIT
  } qida_fsm_t;

  typedef struct packed {
    logic                  en;
    logic [QIDX_W-1:0]     addr;
    logic [OWNER_BITS-1:0] data;
  } qida_tab_wr_t;

endpackage

`default_nettype wire

### src/qida_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qida_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] owner_id;
  logic [7:0]  queue_index;

  modport source (output valid, output opcode, output owner_id, output queue_index,
                  input ready);
  modport sink (input valid, input opcode, input owner_id, input queue_index,
                output ready);
endinterface

interface qida_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  granted_queue;
  logic [15:0] freed_mask;

  modport source (output valid, output status, output granted_queue, output freed_mask,
                  input ready);
  modport sink (input valid, input status, input granted_queue, input freed_mask,
                output ready);
endinterface

`default_nettype wire

### src/qida_owner_tab.sv
`timescale 1ns / 1ps
`default_nettype none

module qida_owner_tab (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire qida_pkg::qida_tab_wr_t            wr,
  input  wire [qida_pkg::QIDX_W-1:0]             raddr,
  input  wire [qida_pkg::OWNER_BITS-1:0]         owner,
  output logic                                   match
);

  logic [qida_pkg::OWNER_BITS-1:0] tab_r [qida_pkg::QUEUE_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < qida_pkg::QUEUE_COUNT; q++) begin
        tab_r[q] <= '0;
      end
    end else if (wr.en) begin
      tab_r[wr.addr] <= wr.data;
    end
  end

  // Single shared comparator: one stored owner is checked per cycle.
  assign match = (tab_r[raddr] == owner);

endmodule

`default_nettype wire

### src/queue_id_allocator_with_owner.sv
`timescale 1ns / 1ps
`default_nettype none

// Queue number allocator with owner record. Each input transaction is one command
// and yields exactly one result transaction. A sequencer walks the queues one per
// cycle through a single owner comparator: init and a check of an out-of-range
// index go straight to the result, a valid check compares one entry, allocate
// stops at the lowest free queue, and release always walks every queue; the result
// register may then wait on the consumer. A new command is taken once the previous
// result is in the output register, even if that result has not yet been taken.

module queue_id_allocator_with_owner (
  input  wire         clk,
  input  wire         rst_n,
  qida_in_if.sink     in_chan,
  qida_out_if.source  out_chan
);

  qida_pkg::qida_fsm_t    state_r, state_nxt;
  qida_pkg::qida_op_t     op_r, op_nxt;
  qida_pkg::qida_status_t status_r, status_nxt;
  qida_pkg::qida_status_t out_status_r, out_status_nxt;

  logic [qida_pkg::OWNER_BITS-1:0]  owner_r, owner_nxt;
  logic [qida_pkg::QIDX_W-1:0]      idx_r, idx_nxt;
  logic [qida_pkg::QIDX_W-1:0]      cnt_r, cnt_nxt;
  logic [qida_pkg::QUEUE_COUNT-1:0] alloc_r, alloc_nxt;
  logic [qida_pkg::GRANT_W-1:0]     granted_r, granted_nxt;
  logic [qida_pkg::QUEUE_COUNT-1:0] freed_r, freed_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [qida_pkg::GRANT_W-1:0]     out_granted_r, out_granted_nxt;
  logic [qida_pkg::FREED_W-1:0]     out_freed_r, out_freed_nxt;

  qida_pkg::qida_tab_wr_t           tab_wr;
  logic [qida_pkg::QIDX_W-1:0]      raddr;
  logic                             match;
  logic                             last;
  logic                             idx_bad;

  qida_owner_tab u_owner_tab (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tab_wr),
    .raddr (raddr),
    .owner (owner_r),
    .match (match)
  );

  assign raddr   = (op_r == qida_pkg::OP_CHECK) ? idx_r : cnt_r;
  assign last    = (cnt_r == qida_pkg::QIDX_W'(qida_pkg::QUEUE_COUNT - 1));
  assign idx_bad = ({1'b0, in_chan.queue_index} >=
                    (qida_pkg::INDEX_W + 1)'(qida_pkg::QUEUE_COUNT));

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    owner_nxt       = owner_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    alloc_nxt       = alloc_r;
    status_nxt      = status_r;
    granted_nxt     = granted_r;
    freed_nxt       = freed_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_freed_nxt   = out_freed_r;
    tab_wr.en       = 1'b0;
    tab_wr.addr     = cnt_r;
    tab_wr.data     = '0;
    in_chan.ready   = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      qida_pkg::FSM_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          op_nxt      = qida_pkg::qida_op_t'(in_chan.opcode);
          owner_nxt   = qida_pkg::OWNER_BITS'(in_chan.owner_id);
          idx_nxt     = qida_pkg::QIDX_W'(in_chan.queue_index);
          cnt_nxt     = '0;
          status_nxt  = qida_pkg::ST_OK;
          granted_nxt = '0;
          freed_nxt   = '0;
          case (qida_pkg::qida_op_t'(in_chan.opcode))
            qida_pkg::OP_INIT: begin
              alloc_nxt = qida_pkg::QUEUE_COUNT'(1);
              state_nxt = qida_pkg::FSM_WAIT;
            end
            qida_pkg::OP_CHECK: begin
              if (idx_bad) begin
                status_nxt = qida_pkg::ST_INVALID;
                state_nxt  = qida_pkg::FSM_WAIT;
              end else begin
                state_nxt = qida_pkg::FSM_SCAN;
              end
            end
            default: begin
              state_nxt = qida_pkg::FSM_SCAN;
            end
          endcase
        end
      end
      qida_pkg::FSM_SCAN: begin
        case (op_r)
          qida_pkg::OP_ALLOC: begin
            if (!alloc_r[cnt_r]) begin
              alloc_nxt[cnt_r] = 1'b1;
              tab_wr.en        = 1'b1;
              tab_wr.data      = owner_r;
              granted_nxt      = qida_pkg::GRANT_W'(cnt_r);
              state_nxt        = qida_pkg::FSM_WAIT;
            end else if (last) begin
              status_nxt = qida_pkg::ST_FULL;
              state_nxt  = qida_pkg::FSM_WAIT;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          qida_pkg::OP_RELEASE: begin
            // Queue 0 is freed by any owner's release.
            if (alloc_r[cnt_r] && (match || cnt_r == '0)) begin
              alloc_nxt[cnt_r] = 1'b0;
              freed_nxt[cnt_r] = 1'b1;
              tab_wr.en        = 1'b1;
            end
            if (last) begin
              state_nxt = qida_pkg::FSM_WAIT;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          qida_pkg::OP_CHECK: begin
            if (!match) begin
              status_nxt = qida_pkg::ST_MISMATCH;
            end
            state_nxt = qida_pkg::FSM_WAIT;
          end
          default: begin
            state_nxt = qida_pkg::FSM_WAIT;
          end
        endcase
      end
      qida_pkg::FSM_WAIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_granted_nxt = granted_r;
          out_freed_nxt   = qida_pkg::FREED_W'(freed_r);
          state_nxt       = qida_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = qida_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qida_pkg::FSM_IDLE;
      alloc_r     <= qida_pkg::QUEUE_COUNT'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alloc_r     <= alloc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    owner_r       <= owner_nxt;
    idx_r         <= idx_nxt;
    cnt_r         <= cnt_nxt;
    status_r      <= status_nxt;
    granted_r     <= granted_nxt;
    freed_r       <= freed_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_freed_r   <= out_freed_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.granted_queue = out_granted_r;
  assign out_chan.freed_mask    = out_freed_r;

  a_init_reserves_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.opcode == qida_pkg::OP_INIT)
      |=> (alloc_r == qida_pkg::QUEUE_COUNT'(1)))
    else $error("init did not leave only queue 0 reserved");

  a_grant_or_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_granted_r == '0 || out_freed_r == '0))
    else $error("result carries both a grant and a freed mask");

  a_wait_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qida_pkg::FSM_WAIT && !out_valid_r) |=> out_valid_r)
    else $error("finished command did not reach the output register");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qida_pkg::FSM_SCAN) |=> !(in_chan.valid && in_chan.ready) ||
      $past(state_nxt) == qida_pkg::FSM_IDLE)
    else $error("command accepted while a scan is in progress");

endmodule

`default_nettype wire
